// ===== hw/rtl/via_pkg.sv =====
// Package for the interface adapter timer and interrupt block.
// Holds the item and result types, action and register codes, and bit positions.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package via_pkg;

    // Action codes of an input word. Codes 6 and 7 are unused and change nothing.
    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_TICK  = 3'd2,
        ACT_CA1   = 3'd3,
        ACT_CA2   = 3'd4,
        ACT_CB1   = 3'd5
    } t_action;

    // Register select codes.
    typedef enum logic [3:0] {
        REG_ORB    = 4'd0,
        REG_ORA    = 4'd1,
        REG_DDRB   = 4'd2,
        REG_DDRA   = 4'd3,
        REG_T1CL   = 4'd4,
        REG_T1CH   = 4'd5,
        REG_T1LL   = 4'd6,
        REG_T1LH   = 4'd7,
        REG_T2CL   = 4'd8,
        REG_T2CH   = 4'd9,
        REG_SR     = 4'd10,
        REG_ACR    = 4'd11,
        REG_PCR    = 4'd12,
        REG_IFR    = 4'd13,
        REG_IER    = 4'd14,
        REG_ORA_NH = 4'd15
    } t_reg_addr;

    localparam int FLAG_W = 7;

    // Interrupt flag bit positions.
    localparam int FLAG_CA2 = 0;
    localparam int FLAG_CA1 = 1;
    localparam int FLAG_CB2 = 3;
    localparam int FLAG_CB1 = 4;
    localparam int FLAG_T2  = 5;
    localparam int FLAG_T1  = 6;

    // Auxiliary control bit positions.
    localparam int ACR_PA_LATCH = 0;
    localparam int ACR_PB_LATCH = 1;
    localparam int ACR_T1_FREE  = 6;
    localparam int ACR_T1_PB7   = 7;

    // Reset values of the port registers.
    localparam logic [7:0] OUT_A_RESET = 8'h80;
    localparam logic [7:0] LAT_B_RESET = 8'hf0;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       edge_level;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/via_if.sv =====
// Valid/ready channel interfaces for the request and result words.
// Depends on via_pkg for the payload types.
`default_nettype none

interface via_req_if;
    logic          valid;
    logic          ready;
    via_pkg::t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface via_rsp_if;
    logic            valid;
    logic            ready;
    via_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/via_core.sv =====
// Register file and state update of the interface adapter.
// Applies one word per enabled cycle and computes its result; depends on via_pkg.
`default_nettype none

module via_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire via_pkg::t_item   i_item,
    output via_pkg::t_result      o_result
);

    localparam int TW = TIMER_BITS;

    logic [7:0]          r_out_a, r_out_b, r_dir_a, r_dir_b, r_lat_a, r_lat_b;
    logic [7:0]          n_out_a, n_out_b, n_dir_a, n_dir_b, n_lat_a, n_lat_b;
    logic [TW-1:0]       r_t1_reload, r_t1_count, r_t2_reload, r_t2_count;
    logic [TW-1:0]       n_t1_reload, n_t1_count, n_t2_reload, n_t2_count;
    logic                r_t1_done, r_t2_done, n_t1_done, n_t2_done;
    logic [7:0]          r_acr, r_pcr, r_shift, n_acr, n_pcr, n_shift;
    logic [via_pkg::FLAG_W-1:0] r_flags, r_enables, n_flags, n_enables;

    logic [15:0] t1_rel_x, t1_cnt_x, t2_rel_x, t2_cnt_x;
    logic [7:0]  pa_value, pb_in, rd;
    logic        irq_now;

    always_comb begin
        t1_rel_x = 16'(r_t1_reload);
        t1_cnt_x = 16'(r_t1_count);
        t2_rel_x = 16'(r_t2_reload);
        t2_cnt_x = 16'(r_t2_count);
        pa_value = (r_out_a & r_dir_a) | (i_item.port_a_pins & ~r_dir_a);
        pb_in    = r_acr[via_pkg::ACR_PB_LATCH] ? r_lat_b : i_item.port_b_pins;
        irq_now  = |(r_flags & r_enables);

        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        n_dir_a     = r_dir_a;
        n_dir_b     = r_dir_b;
        n_lat_a     = r_lat_a;
        n_lat_b     = r_lat_b;
        n_t1_reload = r_t1_reload;
        n_t1_count  = r_t1_count;
        n_t2_reload = r_t2_reload;
        n_t2_count  = r_t2_count;
        n_t1_done   = r_t1_done;
        n_t2_done   = r_t2_done;
        n_acr       = r_acr;
        n_pcr       = r_pcr;
        n_shift     = r_shift;
        n_flags     = r_flags;
        n_enables   = r_enables;
        rd          = 8'h00;

        case (i_item.action)
            via_pkg::ACT_READ: begin
                case (i_item.reg_addr)
                    via_pkg::REG_ORB:  rd = (r_out_b & r_dir_b) | (pb_in & ~r_dir_b);
                    via_pkg::REG_ORA: begin
                        n_flags[via_pkg::FLAG_CA1] = 1'b0;
                        rd = r_acr[via_pkg::ACR_PA_LATCH] ? r_lat_a : pa_value;
                    end
                    via_pkg::REG_DDRB: rd = r_dir_b;
                    via_pkg::REG_DDRA: rd = r_dir_a;
                    via_pkg::REG_T1CL: begin
                        n_flags[via_pkg::FLAG_T1] = 1'b0;
                        rd = t1_cnt_x[7:0];
                    end
                    via_pkg::REG_T1CH: rd = t1_cnt_x[15:8];
                    via_pkg::REG_T1LL: rd = t1_rel_x[7:0];
                    via_pkg::REG_T1LH: rd = t1_rel_x[15:8];
                    via_pkg::REG_T2CL: begin
                        n_flags[via_pkg::FLAG_T2] = 1'b0;
                        rd = t2_cnt_x[7:0];
                    end
                    via_pkg::REG_T2CH: rd = t2_cnt_x[15:8];
                    via_pkg::REG_SR:   rd = r_shift;
                    via_pkg::REG_ACR:  rd = r_acr;
                    via_pkg::REG_PCR:  rd = r_pcr;
                    via_pkg::REG_IFR:  rd = {irq_now, r_flags};
                    via_pkg::REG_IER:  rd = {1'b1, r_enables};
                    default:           rd = pa_value;
                endcase
            end
            via_pkg::ACT_WRITE: begin
                case (i_item.reg_addr)
                    via_pkg::REG_ORB: begin
                        n_out_b = i_item.write_data;
                        n_flags[via_pkg::FLAG_CB2] = 1'b0;
                        n_flags[via_pkg::FLAG_CB1] = 1'b0;
                    end
                    via_pkg::REG_ORA: begin
                        n_out_a = i_item.write_data;
                        n_flags[via_pkg::FLAG_CA2] = 1'b0;
                        n_flags[via_pkg::FLAG_CA1] = 1'b0;
                    end
                    via_pkg::REG_DDRB: n_dir_b = i_item.write_data;
                    via_pkg::REG_DDRA: n_dir_a = i_item.write_data;
                    via_pkg::REG_T1CL, via_pkg::REG_T1LL: begin
                        n_t1_reload = TW'({t1_rel_x[15:8], i_item.write_data});
                    end
                    via_pkg::REG_T1LH: begin
                        n_t1_reload = TW'({i_item.write_data, t1_rel_x[7:0]});
                    end
                    via_pkg::REG_T1CH: begin
                        // Loading the high byte starts timer 1 from the full latch.
                        n_t1_reload = TW'({i_item.write_data, t1_rel_x[7:0]});
                        n_t1_count  = n_t1_reload;
                        n_flags[via_pkg::FLAG_T1] = 1'b0;
                        if (r_acr[via_pkg::ACR_T1_PB7]) begin
                            n_out_b[7] = 1'b0;
                            n_lat_b[7] = 1'b0;
                        end
                        n_t1_done = 1'b0;
                    end
                    via_pkg::REG_T2CL: begin
                        n_t2_reload = TW'({t2_rel_x[15:8], i_item.write_data});
                    end
                    via_pkg::REG_T2CH: begin
                        n_t2_reload = TW'({i_item.write_data, t2_rel_x[7:0]});
                        n_t2_count  = n_t2_reload;
                        n_flags[via_pkg::FLAG_T2] = 1'b0;
                        n_t2_done = 1'b0;
                    end
                    via_pkg::REG_SR:  n_shift = i_item.write_data;
                    via_pkg::REG_ACR: n_acr = i_item.write_data;
                    via_pkg::REG_PCR: n_pcr = i_item.write_data;
                    via_pkg::REG_IFR: n_flags = r_flags & ~i_item.write_data[6:0];
                    via_pkg::REG_IER: begin
                        if (i_item.write_data[7]) begin
                            n_enables = r_enables | i_item.write_data[6:0];
                        end else begin
                            n_enables = r_enables & ~i_item.write_data[6:0];
                        end
                    end
                    default: n_out_a = i_item.write_data;
                endcase
            end
            via_pkg::ACT_TICK: begin
                // A zero count reloads instead of decrementing.
                if (r_t1_count == '0) begin
                    n_t1_count = r_t1_reload;
                    if (!r_t1_done || r_acr[via_pkg::ACR_T1_FREE]) begin
                        n_flags[via_pkg::FLAG_T1] = 1'b1;
                        if (r_acr[via_pkg::ACR_T1_PB7]) begin
                            n_out_b[7] = ~r_out_b[7];
                            n_lat_b[7] = ~r_lat_b[7];
                        end
                    end
                    n_t1_done = 1'b1;
                end else begin
                    n_t1_count = r_t1_count - TW'(1);
                end
                if (r_t2_count == '0) begin
                    n_t2_count = r_t2_reload;
                    if (!r_t2_done) begin
                        n_flags[via_pkg::FLAG_T2] = 1'b1;
                    end
                    n_t2_done = 1'b1;
                end else begin
                    n_t2_count = r_t2_count - TW'(1);
                end
            end
            via_pkg::ACT_CA1: begin
                if (r_pcr[0] == i_item.edge_level) begin
                    n_flags[via_pkg::FLAG_CA1] = 1'b1;
                    n_lat_a = pa_value;
                end
            end
            via_pkg::ACT_CA2: n_flags[via_pkg::FLAG_CA2] = 1'b1;
            via_pkg::ACT_CB1: n_flags[via_pkg::FLAG_CB1] = 1'b1;
            default: ;
        endcase

        o_result.read_data    = rd;
        o_result.irq          = |(n_flags & n_enables);
        o_result.port_a_drive = n_out_a & n_dir_a;
        o_result.port_b_drive = n_out_b & n_dir_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_a     <= via_pkg::OUT_A_RESET;
            r_out_b     <= '0;
            r_dir_a     <= '0;
            r_dir_b     <= '0;
            r_lat_a     <= '0;
            r_lat_b     <= via_pkg::LAT_B_RESET;
            r_t1_reload <= '1;
            r_t1_count  <= '1;
            r_t2_reload <= '1;
            r_t2_count  <= '1;
            r_t1_done   <= 1'b0;
            r_t2_done   <= 1'b0;
            r_acr       <= '0;
            r_pcr       <= '0;
            r_shift     <= '0;
            r_flags     <= '0;
            r_enables   <= '0;
        end else if (i_fire) begin
            r_out_a     <= n_out_a;
            r_out_b     <= n_out_b;
            r_dir_a     <= n_dir_a;
            r_dir_b     <= n_dir_b;
            r_lat_a     <= n_lat_a;
            r_lat_b     <= n_lat_b;
            r_t1_reload <= n_t1_reload;
            r_t1_count  <= n_t1_count;
            r_t2_reload <= n_t2_reload;
            r_t2_count  <= n_t2_count;
            r_t1_done   <= n_t1_done;
            r_t2_done   <= n_t2_done;
            r_acr       <= n_acr;
            r_pcr       <= n_pcr;
            r_shift     <= n_shift;
            r_flags     <= n_flags;
            r_enables   <= n_enables;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/via_timer_interrupt_block.sv =====
// Top level of the 6522-style timer and interrupt block.
// Depends on via_pkg, the channel interfaces in via_if.sv and via_core.
//
// The block takes one request word per clock while the downstream side takes
// results, and returns exactly one result word for each, in order. A word is a
// bus read or write of one of the sixteen registers, a timer tick, or a CA1, CA2
// or CB1 event; the result carries the byte read (zero for anything but a read),
// the irq level and the port A and B drive values after the word has been
// applied. An accepted word is captured in an input register, applied to the
// register file by a single pass of combinational logic once the output register
// is free or being emptied, and its result is captured in an output register.
// The word rate is set by the single register-file update; while a finished result
// waits for the downstream side, the input register still takes one more word
// and then holds the request side off until the result is taken. TIMER_BITS sets
// the width of both timers and their latches (8 to 16); narrower timers drop the
// upper latch bits and read zero there.
`default_nettype none

module via_timer_interrupt_block #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    via_req_if.sink   i_req,
    via_rsp_if.source o_rsp
);

    via_pkg::t_item   r_item;
    logic             r_item_vld;
    via_pkg::t_result r_res;
    logic             r_res_vld;
    via_pkg::t_result core_result;
    logic             fire;

    // The held word is applied when the output register is free or being emptied.
    assign fire        = r_item_vld && (!r_res_vld || o_rsp.ready);
    assign i_req.ready = !r_item_vld || fire;

    assign o_rsp.valid   = r_res_vld;
    assign o_rsp.payload = r_res;

    via_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_item_vld <= 1'b1;
            end else if (fire) begin
                r_item_vld <= 1'b0;
            end
            if (fire) begin
                r_res_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= i_req.payload;
        end
        if (fire) begin
            r_res <= core_result;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/via_checker.sv =====
// Port-level checks for via_timer_interrupt_block, attached by a bind statement.
// Depends on via_pkg for the result type.
`default_nettype none

module via_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire via_pkg::t_result i_rsp_payload
);

    // A result that is not taken holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("result word changed or dropped while stalled");

    // Reset empties the output stage.
    a_rsp_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // With no result pending the block never refuses a request word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request stalled with an empty output stage");

    // A word taken while the output is empty is followed by a valid result word.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && !i_rsp_valid |=> ##1 i_rsp_valid)
        else $error("accepted word produced no result");

endmodule

bind via_timer_interrupt_block via_checker u_via_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

`default_nettype wire

// ===== bench/via_timer_interrupt_block_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for via_timer_interrupt_block: a clocked driver feeds request words
// from a queue, a clocked monitor checks each result word against a local register model.
// Depends on via_pkg and the channel interfaces in via_if.sv.

module via_timer_interrupt_block_tb;

    localparam int TIMER_BITS = 16;
    localparam logic [15:0] TMASK = 16'((32'd1 << TIMER_BITS) - 1);

    // Action codes that the block must ignore.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int TOTAL_WORDS = 1550;
    localparam int MID_DRAIN_AT = 800;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        via_pkg::t_item word;
        bit             drain;
    } t_bus_word;

    logic i_clk;
    logic i_rst_n;

    via_req_if req_ch ();
    via_rsp_if rsp_ch ();

    via_timer_interrupt_block #(
        .TIMER_BITS(TIMER_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Request words waiting to be offered, and the results the model predicts for
    // words already accepted, oldest first.
    t_bus_word        bus_words[$];
    via_pkg::t_result via_result_q[$];

    int word_count = 0;
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    // Register model state, at its reset values.
    logic [7:0] ora_q = via_pkg::OUT_A_RESET;
    logic [7:0] orb_q = '0;
    logic [7:0] ddra_q = '0;
    logic [7:0] ddrb_q = '0;
    logic [7:0] pa_latch_q = '0;
    logic [7:0] pb_latch_q = via_pkg::LAT_B_RESET;
    logic [15:0] t1_latch = TMASK;
    logic [15:0] t1_cnt = TMASK;
    logic [15:0] t2_latch = TMASK;
    logic [15:0] t2_cnt = TMASK;
    logic t1_fired = 1'b0;
    logic t2_fired = 1'b0;
    logic [7:0] acr_q = '0;
    logic [7:0] pcr_q = '0;
    logic [via_pkg::FLAG_W-1:0] ifr_q = '0;
    logic [via_pkg::FLAG_W-1:0] ier_q = '0;
    logic [7:0] sr_q = '0;

    // Applies one accepted word to the model and returns the result it should produce.
    function automatic via_pkg::t_result via_apply_word(via_pkg::t_item w);
        via_pkg::t_result r;
        logic [7:0] rd;
        logic [7:0] pa_val;
        logic [7:0] pb_in;
        logic [7:0] v;
        rd = '0;
        v = w.write_data;
        pa_val = (ora_q & ddra_q) | (w.port_a_pins & ~ddra_q);
        pb_in = acr_q[via_pkg::ACR_PB_LATCH] ? pb_latch_q : w.port_b_pins;
        case (w.action)
            via_pkg::ACT_READ: begin
                case (w.reg_addr)
                    via_pkg::REG_ORB: rd = (orb_q & ddrb_q) | (pb_in & ~ddrb_q);
                    via_pkg::REG_ORA: begin
                        ifr_q[via_pkg::FLAG_CA1] = 1'b0;
                        rd = acr_q[via_pkg::ACR_PA_LATCH] ? pa_latch_q : pa_val;
                    end
                    via_pkg::REG_DDRB: rd = ddrb_q;
                    via_pkg::REG_DDRA: rd = ddra_q;
                    via_pkg::REG_T1CL: begin
                        ifr_q[via_pkg::FLAG_T1] = 1'b0;
                        rd = t1_cnt[7:0];
                    end
                    via_pkg::REG_T1CH: rd = t1_cnt[15:8];
                    via_pkg::REG_T1LL: rd = t1_latch[7:0];
                    via_pkg::REG_T1LH: rd = t1_latch[15:8];
                    via_pkg::REG_T2CL: begin
                        ifr_q[via_pkg::FLAG_T2] = 1'b0;
                        rd = t2_cnt[7:0];
                    end
                    via_pkg::REG_T2CH: rd = t2_cnt[15:8];
                    via_pkg::REG_SR: rd = sr_q;
                    via_pkg::REG_ACR: rd = acr_q;
                    via_pkg::REG_PCR: rd = pcr_q;
                    via_pkg::REG_IFR: rd = {|(ifr_q & ier_q), ifr_q};
                    via_pkg::REG_IER: rd = {1'b1, ier_q};
                    default: rd = pa_val;
                endcase
            end
            via_pkg::ACT_WRITE: begin
                case (w.reg_addr)
                    via_pkg::REG_ORB: begin
                        orb_q = v;
                        ifr_q[via_pkg::FLAG_CB1] = 1'b0;
                        ifr_q[via_pkg::FLAG_CB2] = 1'b0;
                    end
                    via_pkg::REG_ORA: begin
                        ora_q = v;
                        ifr_q[via_pkg::FLAG_CA1] = 1'b0;
                        ifr_q[via_pkg::FLAG_CA2] = 1'b0;
                    end
                    via_pkg::REG_DDRB: ddrb_q = v;
                    via_pkg::REG_DDRA: ddra_q = v;
                    via_pkg::REG_T1CL, via_pkg::REG_T1LL: begin
                        t1_latch = {t1_latch[15:8], v} & TMASK;
                    end
                    via_pkg::REG_T1LH: t1_latch = {v, t1_latch[7:0]} & TMASK;
                    via_pkg::REG_T1CH: begin
                        t1_latch = {v, t1_latch[7:0]} & TMASK;
                        t1_cnt = t1_latch;
                        ifr_q[via_pkg::FLAG_T1] = 1'b0;
                        if (acr_q[via_pkg::ACR_T1_PB7]) begin
                            orb_q[7] = 1'b0;
                            pb_latch_q[7] = 1'b0;
                        end
                        t1_fired = 1'b0;
                    end
                    via_pkg::REG_T2CL: t2_latch = {t2_latch[15:8], v} & TMASK;
                    via_pkg::REG_T2CH: begin
                        t2_latch = {v, t2_latch[7:0]} & TMASK;
                        t2_cnt = t2_latch;
                        ifr_q[via_pkg::FLAG_T2] = 1'b0;
                        t2_fired = 1'b0;
                    end
                    via_pkg::REG_SR: sr_q = v;
                    via_pkg::REG_ACR: acr_q = v;
                    via_pkg::REG_PCR: pcr_q = v;
                    via_pkg::REG_IFR: ifr_q = ifr_q & ~v[via_pkg::FLAG_W-1:0];
                    via_pkg::REG_IER: begin
                        if (v[7]) begin
                            ier_q = ier_q | v[via_pkg::FLAG_W-1:0];
                        end else begin
                            ier_q = ier_q & ~v[via_pkg::FLAG_W-1:0];
                        end
                    end
                    default: ora_q = v;
                endcase
            end
            via_pkg::ACT_TICK: begin
                // A timer at zero reloads instead of decrementing. Timer 1 fires again
                // on every reload only in free-running mode; timer 2 fires only once.
                if (t1_cnt == '0) begin
                    t1_cnt = t1_latch;
                    if (!t1_fired || acr_q[via_pkg::ACR_T1_FREE]) begin
                        ifr_q[via_pkg::FLAG_T1] = 1'b1;
                        if (acr_q[via_pkg::ACR_T1_PB7]) begin
                            orb_q[7] = ~orb_q[7];
                            pb_latch_q[7] = ~pb_latch_q[7];
                        end
                    end
                    t1_fired = 1'b1;
                end else begin
                    t1_cnt = (t1_cnt - 16'd1) & TMASK;
                end
                if (t2_cnt == '0) begin
                    t2_cnt = t2_latch;
                    if (!t2_fired) begin
                        ifr_q[via_pkg::FLAG_T2] = 1'b1;
                    end
                    t2_fired = 1'b1;
                end else begin
                    t2_cnt = (t2_cnt - 16'd1) & TMASK;
                end
            end
            via_pkg::ACT_CA1: begin
                if (pcr_q[0] == w.edge_level) begin
                    ifr_q[via_pkg::FLAG_CA1] = 1'b1;
                    pa_latch_q = pa_val;
                end
            end
            via_pkg::ACT_CA2: ifr_q[via_pkg::FLAG_CA2] = 1'b1;
            via_pkg::ACT_CB1: ifr_q[via_pkg::FLAG_CB1] = 1'b1;
            default: ;
        endcase
        r.read_data = rd;
        r.irq = |(ifr_q & ier_q);
        r.port_a_drive = ora_q & ddra_q;
        r.port_b_drive = orb_q & ddrb_q;
        return r;
    endfunction

    // Builds a request word; the pins and the CA1 level are random.
    function automatic via_pkg::t_item via_word(logic [2:0] act, logic [3:0] addr,
                                                logic [7:0] data);
        via_pkg::t_item w;
        w.action = act;
        w.reg_addr = addr;
        w.write_data = data;
        w.edge_level = 1'($urandom_range(0, 1));
        w.port_a_pins = 8'($urandom);
        w.port_b_pins = 8'($urandom);
        return w;
    endfunction

    // Appends a word to the stimulus. With drain set, the driver holds the word back
    // until every earlier result has come back.
    function automatic void queue_word(via_pkg::t_item w, bit drain);
        t_bus_word bw;
        bw.word = w;
        bw.drain = drain;
        bus_words.push_back(bw);
        word_count++;
    endfunction

    function automatic int idle_cycles(bit burst);
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    // Clock and the single reset pulse at the start of the run.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Driver. An accepted word is predicted at the edge where it is taken. When the
    // next word has no idle gap, valid simply stays high with new payload, so valid
    // gets exactly one nonblocking update per edge.
    always @(posedge i_clk) begin : driver
        logic offer;
        offer = req_ch.valid;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                via_result_q.push_back(via_apply_word(req_ch.payload));
                offer = 1'b0;
                if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
                gap_left = idle_cycles(send_burst);
            end
            if (!offer && bus_words.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(bus_words[0].drain && via_result_q.size() > 0)) begin
                    req_ch.payload <= bus_words[0].word;
                    bus_words.pop_front();
                    offer = 1'b1;
                end
            end
        end
        req_ch.valid <= offer;
    end

    // Monitor. Every accepted result is checked against the oldest prediction. Ready
    // then drops for a random number of cycles; once, it stays low for a long stretch
    // so that both pipeline registers fill and the block stalls its input side.
    always @(posedge i_clk) begin : monitor
        via_pkg::t_result want;
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (via_result_q.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    mismatches++;
                end else begin
                    want = via_result_q.pop_front();
                    if (rsp_ch.payload.read_data !== want.read_data) begin
                        $error("read_data: expected %02h, actual %02h",
                               want.read_data, rsp_ch.payload.read_data);
                        mismatches++;
                    end
                    if (rsp_ch.payload.irq !== want.irq) begin
                        $error("irq: expected %0b, actual %0b",
                               want.irq, rsp_ch.payload.irq);
                        mismatches++;
                    end
                    if (rsp_ch.payload.port_a_drive !== want.port_a_drive) begin
                        $error("port_a_drive: expected %02h, actual %02h",
                               want.port_a_drive, rsp_ch.payload.port_a_drive);
                        mismatches++;
                    end
                    if (rsp_ch.payload.port_b_drive !== want.port_b_drive) begin
                        $error("port_b_drive: expected %02h, actual %02h",
                               want.port_b_drive, rsp_ch.payload.port_b_drive);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
                stall_left = idle_cycles(recv_burst);
                if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                rdy = 1'b1;
            end
        end
        rsp_ch.ready <= rdy;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        via_pkg::t_item w;
        int kind;
        int n;
        bit pick_t1;
        logic [7:0] hi;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;

        // Directed part: reset values, port drive at the data extremes, both timers
        // expiring in free-running PB7 mode, the CA1 level match and mismatch, the
        // other events, the input latches, register 15 and the unused action codes.
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_IFR, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_IER, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_DDRA, 8'hff), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_DDRB, 8'hff), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_ORA, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_ORB, 8'hff), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_IER, 8'hff), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_ACR, 8'hc0), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T1LL, 8'h01), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T1CH, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T2CL, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T2CH, 8'h00), 1'b0);
        repeat (5) queue_word(via_word(via_pkg::ACT_TICK, via_pkg::REG_ORB, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_T1CL, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_DDRA, 8'h0f), 1'b0);
        w = via_word(via_pkg::ACT_CA1, via_pkg::REG_ORB, 8'h00);
        w.edge_level = 1'b0;
        w.port_a_pins = 8'hff;
        queue_word(w, 1'b0);
        w.edge_level = 1'b1;
        w.port_a_pins = 8'h00;
        queue_word(w, 1'b0);
        queue_word(via_word(via_pkg::ACT_CA2, via_pkg::REG_ORB, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_CB1, via_pkg::REG_ORB, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_ACR, 8'h03), 1'b0);
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_ORA, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_ORB, 8'h00), 1'b0);
        queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_ORA_NH, 8'h5a), 1'b0);
        queue_word(via_word(ACT_SPARE_LO, via_pkg::REG_IFR, 8'hff), 1'b0);
        queue_word(via_word(ACT_SPARE_HI, via_pkg::REG_ORA_NH, 8'hff), 1'b0);

        // Random part. Most of it programs a timer with a short count and then ticks
        // it through expiry, so that flags, irq and PB7 toggling are reached often.
        // The first random word waits for the pipeline to empty.
        queue_word(via_word(via_pkg::ACT_READ, via_pkg::REG_IFR, 8'h00), 1'b1);
        while (word_count < TOTAL_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                pick_t1 = 1'($urandom_range(0, 1));
                hi = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 1)) : 8'h00;
                if (pick_t1) begin
                    queue_word(via_word(via_pkg::ACT_WRITE,
                                        $urandom_range(0, 1) ? via_pkg::REG_T1LL
                                                             : via_pkg::REG_T1CL,
                                        8'($urandom_range(0, 6))), 1'b0);
                    queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T1CH, hi), 1'b0);
                end else begin
                    queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T2CL,
                                        8'($urandom_range(0, 6))), 1'b0);
                    queue_word(via_word(via_pkg::ACT_WRITE, via_pkg::REG_T2CH, hi), 1'b0);
                end
                n = $urandom_range(1, 14);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        queue_word(via_word(via_pkg::ACT_READ,
                                            4'($urandom_range(0, 15)), 8'h00),
                                   word_count == MID_DRAIN_AT);
                    end else begin
                        queue_word(via_word(via_pkg::ACT_TICK, 4'($urandom),
                                            8'($urandom)),
                                   word_count == MID_DRAIN_AT);
                    end
                end
            end else if (kind < 55) begin
                queue_word(via_word(via_pkg::ACT_WRITE, 4'($urandom_range(0, 15)),
                                    8'($urandom)),
                           word_count == MID_DRAIN_AT);
            end else if (kind < 75) begin
                queue_word(via_word(via_pkg::ACT_READ, 4'($urandom_range(0, 15)),
                                    8'($urandom)),
                           word_count == MID_DRAIN_AT);
            end else if (kind < 90) begin
                queue_word(via_word(3'($urandom_range(via_pkg::ACT_CA1, via_pkg::ACT_CB1)),
                                    4'($urandom), 8'($urandom)),
                           word_count == MID_DRAIN_AT);
            end else if (kind < 95) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    queue_word(via_word(via_pkg::ACT_TICK, 4'($urandom), 8'($urandom)),
                               word_count == MID_DRAIN_AT);
                end
            end else begin
                // Noise: any action code, the unused ones included.
                queue_word(via_word(3'($urandom), 4'($urandom), 8'($urandom)),
                           word_count == MID_DRAIN_AT);
            end
        end

        while (bus_words.size() != 0 || req_ch.valid || via_result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/via_pkg.sv
hw/rtl/via_if.sv
hw/rtl/via_core.sv
hw/rtl/via_timer_interrupt_block.sv
hw/rtl/via_checker.sv
bench/via_timer_interrupt_block_tb.sv
